@@ sv/tbrfp_pkg.sv @@
`default_nettype none
package tbrfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned PosW = 3;
	localparam int unsigned IdW = 16;
	localparam int unsigned ValW = 32;
	localparam int unsigned EvW = 3;

	localparam logic [ByteW-1:0] StartByteRst = 8'h7E;
	localparam logic [ByteW-1:0] HeaderByteRst = 8'h10;
	localparam logic [ByteW-1:0] OwnIdRst = 8'h00;
	localparam logic [ByteW-1:0] SumGood = 8'hFF;
	localparam logic [PosW-1:0] LastPos = 3'd7;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_BYTE  = 2'd0,
		CFG_HEADER_BYTE = 2'd1,
		CFG_OWN_ID      = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_WAIT_START = 2'd0,
		PH_WAIT_ID    = 2'd1,
		PH_FRAME      = 2'd2
	} phase_t;

	typedef enum logic [EvW-1:0] {
		EV_NONE       = 3'd0,
		EV_POLL_OURS  = 3'd1,
		EV_POLL_OTHER = 3'd2,
		EV_FRAME_GOOD = 3'd3,
		EV_FRAME_BAD  = 3'd4
	} event_t;

	typedef struct packed {
		logic [EvW-1:0]   event_code;
		logic [ByteW-1:0] polled_id;
		logic [IdW-1:0]   frame_data_id;
		logic [ValW-1:0]  frame_value;
	} result_t;

	// one's-complement style byte add: carry out wraps back into bit 0
	function automatic logic [ByteW-1:0] add_end_around(input logic [ByteW-1:0] acc,
			input logic [ByteW-1:0] b);
		logic [ByteW:0] s;
		s = {1'b0, acc} + {1'b0, b};
		return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
	endfunction

endpackage
`default_nettype wire

@@ sv/tbrfp_parser.sv @@
`default_nettype none
module tbrfp_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tbrfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [tbrfp_pkg::ByteW-1:0]     cfg_data,
	input  wire logic                            take,
	input  wire logic [tbrfp_pkg::ByteW-1:0]     rx_byte,
	output tbrfp_pkg::result_t                   res
);

	tbrfp_pkg::phase_t phase_q, phase_d;
	logic [tbrfp_pkg::ByteW-1:0] start_byte_q, header_byte_q, own_id_q;
	logic [tbrfp_pkg::PosW-1:0]  pos_q, pos_d;
	logic [tbrfp_pkg::ByteW-1:0] sum_q, sum_d, sum_add;
	logic [tbrfp_pkg::IdW-1:0]   id_q, id_d;
	logic [tbrfp_pkg::ValW-1:0]  val_q, val_d;
	logic [tbrfp_pkg::ByteW-1:0] polled_q, polled_d;
	logic frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= tbrfp_pkg::StartByteRst;
			header_byte_q <= tbrfp_pkg::HeaderByteRst;
			own_id_q      <= tbrfp_pkg::OwnIdRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbrfp_pkg::CFG_START_BYTE:  start_byte_q  <= cfg_data;
				tbrfp_pkg::CFG_HEADER_BYTE: header_byte_q <= cfg_data;
				tbrfp_pkg::CFG_OWN_ID:      own_id_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sum_add = tbrfp_pkg::add_end_around(sum_q, rx_byte);
	assign frame_done = (pos_q >= tbrfp_pkg::LastPos);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			tbrfp_pkg::PH_WAIT_START: begin
				priority if (rx_byte == start_byte_q) phase_d = tbrfp_pkg::PH_WAIT_ID;
				else if (rx_byte == header_byte_q) phase_d = tbrfp_pkg::PH_FRAME;
				else phase_d = phase_q;
			end
			tbrfp_pkg::PH_WAIT_ID: phase_d = tbrfp_pkg::PH_WAIT_START;
			tbrfp_pkg::PH_FRAME: begin
				if (frame_done) phase_d = tbrfp_pkg::PH_WAIT_START;
			end
			default: phase_d = tbrfp_pkg::PH_WAIT_START;
		endcase
	end

	// datapath and result
	always_comb begin
		pos_d    = pos_q;
		sum_d    = sum_q;
		id_d     = id_q;
		val_d    = val_q;
		polled_d = polled_q;
		res.event_code    = tbrfp_pkg::EV_NONE;
		res.frame_data_id = '0;
		res.frame_value   = '0;
		unique case (phase_q)
			tbrfp_pkg::PH_WAIT_START: begin
				if (rx_byte != start_byte_q && rx_byte == header_byte_q) begin
					pos_d = tbrfp_pkg::PosW'(1);
					sum_d = tbrfp_pkg::add_end_around('0, rx_byte);
					id_d  = '0;
					val_d = '0;
				end
			end
			tbrfp_pkg::PH_WAIT_ID: begin
				polled_d = rx_byte;
				res.event_code = (rx_byte == own_id_q) ? tbrfp_pkg::EV_POLL_OURS
					: tbrfp_pkg::EV_POLL_OTHER;
			end
			tbrfp_pkg::PH_FRAME: begin
				sum_d = sum_add;
				// bytes 1-2 data id, 3-6 value, both little-endian
				if (pos_q == 3'd1 || pos_q == 3'd2)
					id_d = {rx_byte, id_q[tbrfp_pkg::IdW-1:tbrfp_pkg::ByteW]};
				else if (pos_q >= 3'd3 && pos_q <= 3'd6)
					val_d = {rx_byte, val_q[tbrfp_pkg::ValW-1:tbrfp_pkg::ByteW]};
				if (frame_done) begin
					pos_d = '0;
					if (sum_add == tbrfp_pkg::SumGood) begin
						res.event_code    = tbrfp_pkg::EV_FRAME_GOOD;
						res.frame_data_id = id_q;
						res.frame_value   = val_q;
					end else begin
						res.event_code = tbrfp_pkg::EV_FRAME_BAD;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			default: ;
		endcase
		res.polled_id = polled_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tbrfp_pkg::PH_WAIT_START;
			pos_q    <= '0;
			sum_q    <= '0;
			id_q     <= '0;
			val_q    <= '0;
			polled_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			id_q     <= id_d;
			val_q    <= val_d;
			polled_q <= polled_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/tbrfp_out_buf.sv @@
`default_nettype none
module tbrfp_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  tbrfp_pkg::result_t push_data,
	output logic               can_push,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tbrfp_pkg::result_t out_data
);

	logic main_v_q, skid_v_q;
	tbrfp_pkg::result_t main_q, skid_q;
	logic pop;

	assign pop       = main_v_q && out_ready;
	assign can_push  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) skid_v_q <= 1'b0;
			else main_v_q <= push;
		end else if (push) begin
			if (main_v_q) skid_v_q <= 1'b1;
			else main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) main_q <= skid_q;
			else if (push) main_q <= push_data;
		end else if (push) begin
			if (main_v_q) skid_q <= push_data;
			else main_q <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ sv/telemetry_bus_rx_frame_parser_core.sv @@
// Telemetry bus receive frame parser.
// in channel: one received byte per beat (rx_byte, in_valid/in_ready).
// out channel: one result beat per input beat (event_code, polled_id,
//   frame_data_id, frame_value) on out_valid/out_ready, in input order.
// Config: cfg_we/cfg_index/cfg_data write start byte, data header byte and
//   own sensor id; write only while the block is idle.
// Output: a result is registered into the output buffer when its byte is taken.
// Throughput: one byte per cycle while in_ready is high; the parser state
//   updates on take and the result lands in a two-entry output buffer.
// When the receiver stalls the buffer holds up to two results; in_ready drops
//   only once both entries are full, and rises again after one is taken.
// Reset: config registers return to 0x7E / 0x10 / 0x00, the parser returns
//   to waiting for a start byte and the output buffer empties.
`default_nettype none
module telemetry_bus_rx_frame_parser_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbrfp_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [tbrfp_pkg::ByteW-1:0]         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [tbrfp_pkg::ByteW-1:0]         rx_byte,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [tbrfp_pkg::EvW-1:0]                event_code,
	output logic [tbrfp_pkg::ByteW-1:0]              polled_id,
	output logic [tbrfp_pkg::IdW-1:0]                frame_data_id,
	output logic [tbrfp_pkg::ValW-1:0]               frame_value
);

	logic take;
	tbrfp_pkg::result_t res, out_res;

	assign take = in_valid && in_ready;

	tbrfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.rx_byte   (rx_byte),
		.res       (res)
	);

	tbrfp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign event_code    = out_res.event_code;
	assign polled_id     = out_res.polled_id;
	assign frame_data_id = out_res.frame_data_id;
	assign frame_value   = out_res.frame_value;

endmodule
`default_nettype wire
